// File: rtl/ugm_pkg.sv
// Shared constants, codes and types of the upwind gradient magnitude unit.
// No dependencies; every other file imports this package.

package ugm_pkg;

   // fixed-point layout
   localparam int FRACTION_BITS = 16;
   localparam int FACE_W  = 16;                       // face value, Q0.F
   localparam int SPACE_W = 24;                       // spacing
   localparam int GRAD_W  = 32;                       // signed gradient
   localparam int MODE_W  = 2;
   localparam int SUM_W   = 64;                       // sum of squares
   localparam int ROOT_W  = SUM_W / 2;
   localparam int MAG_W   = 32;
   localparam int DVD_W   = FACE_W + FRACTION_BITS;   // dividend and quotient

   // shared compare-subtract width, sized for the root recurrence
   localparam int CSUB_W  = ROOT_W + 3;
   localparam int REM_W   = CSUB_W - 1;

   localparam int STEP_MAX = (DVD_W > ROOT_W) ? DVD_W : ROOT_W;
   localparam int STEP_W   = $clog2(STEP_MAX);

   localparam logic [GRAD_W-1:0] GRAD_CAP = {1'b0, {(GRAD_W-1){1'b1}}};

   typedef enum logic [MODE_W-1:0] {
      MODE_OFF      = 2'd0,
      MODE_DIFF     = 2'd1,
      MODE_SMOOTH   = 2'd2,
      MODE_DIFF_ALT = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CLAMP,
      ST_SQUARE,
      ST_ACCUM,
      ST_ROOT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                      flux_nonnegative;
      logic [FACE_W-1:0]         upper_own;
      logic [FACE_W-1:0]         lower_own;
      logic [SPACE_W-1:0]        spacing_own;
      logic [FACE_W-1:0]         upper_next;
      logic [FACE_W-1:0]         lower_next;
      logic [SPACE_W-1:0]        spacing_next;
      logic signed [GRAD_W-1:0]  gradient_own;
      logic signed [GRAD_W-1:0]  gradient_next;
      logic                      last_axis;
   } item_type;

   typedef struct packed {
      logic     start;
      mode_type mode;
   } cmd_type;

   typedef struct packed {
      logic idle;
      logic done;
   } status_type;

endpackage

// File: rtl/ugm_ifs.sv
// Channel interfaces of the upwind gradient magnitude unit: item, result, register write.
// Depends on ugm_pkg.

interface ugm_req_if import ugm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      flux_nonnegative;
   logic [FACE_W-1:0]         upper_own;
   logic [FACE_W-1:0]         lower_own;
   logic [SPACE_W-1:0]        spacing_own;
   logic [FACE_W-1:0]         upper_next;
   logic [FACE_W-1:0]         lower_next;
   logic [SPACE_W-1:0]        spacing_next;
   logic signed [GRAD_W-1:0]  gradient_own;
   logic signed [GRAD_W-1:0]  gradient_next;
   logic                      last_axis;

   modport source (
      output valid, flux_nonnegative, upper_own, lower_own, spacing_own,
             upper_next, lower_next, spacing_next, gradient_own, gradient_next,
             last_axis,
      input  ready
   );
   modport sink (
      input  valid, flux_nonnegative, upper_own, lower_own, spacing_own,
             upper_next, lower_next, spacing_next, gradient_own, gradient_next,
             last_axis,
      output ready
   );
endinterface

interface ugm_rsp_if import ugm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MAG_W-1:0]  magnitude;

   modport source (output valid, magnitude, input ready);
   modport sink   (input valid, magnitude, output ready);
endinterface

interface ugm_csr_if import ugm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: rtl/upwind_gradient_magnitude_unit.sv
// Top level of the upwind gradient magnitude unit: channels, mode register, result register.
// Depends on ugm_pkg, ugm_ifs, ugm_engine.
//
//   port     dir   word                                   handshake
//   req_ch   in    one axis of a cell (upwind operands)   valid/ready
//   rsp_ch   out   magnitude, unsigned Q16.16             valid/ready
//   csr_ch   in    gradient_mode, 2 bits                  valid/ready, always ready
//
// Difference-mode axis with unequal faces and nonzero spacing: the sequencer
// runs the 32-step serial divide on the shared compare-subtract unit before
// the square and accumulate steps; other axes skip the divide. The last axis
// adds the 32-step square root on the same unit plus the hand-off to the
// result register. req_ch.ready is high only while the sequencer is idle.
// Synchronous active-high reset: mode 1, sum of squares zero, no result pending.
// A stalled result holds in its register; the next cell accumulates meanwhile
// and only its final hand-off waits for the register to drain.

module upwind_gradient_magnitude_unit import ugm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ugm_req_if.sink    req_ch,
   ugm_rsp_if.source  rsp_ch,
   ugm_csr_if.sink    csr_ch
);

   mode_type          mode_ff, mode_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0]  rsp_mag_ff, rsp_mag_in;

   cmd_type           cmd;
   item_type          item;
   status_type        stat;
   logic              out_free;
   logic [MAG_W-1:0]  eng_mag;

   ugm_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .item      (item),
      .out_free  (out_free),
      .stat      (stat),
      .magnitude (eng_mag)
   );

   // input side
   always_comb begin
      item.flux_nonnegative = req_ch.flux_nonnegative;
      item.upper_own        = req_ch.upper_own;
      item.lower_own        = req_ch.lower_own;
      item.spacing_own      = req_ch.spacing_own;
      item.upper_next       = req_ch.upper_next;
      item.lower_next       = req_ch.lower_next;
      item.spacing_next     = req_ch.spacing_next;
      item.gradient_own     = req_ch.gradient_own;
      item.gradient_next    = req_ch.gradient_next;
      item.last_axis        = req_ch.last_axis;
      cmd.start             = req_ch.valid & stat.idle;
      cmd.mode              = mode_ff;
   end

   assign req_ch.ready = stat.idle;
   assign csr_ch.ready = 1'b1;

   // mode register; the user must write it only between cells (not enforced here)
   always_comb begin
      mode_in = mode_ff;
      if (csr_ch.valid) begin
         mode_in = mode_type'(csr_ch.data);
      end
   end

   // result register; frees up in the same cycle it is taken
   always_comb begin
      out_free     = ~rsp_valid_ff | rsp_ch.ready;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_mag_in   = rsp_mag_ff;
      if (stat.done) begin
         rsp_valid_in = 1'b1;
         rsp_mag_in   = eng_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_DIFF;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_mag_ff <= rsp_mag_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.magnitude = rsp_mag_ff;

   // an accepted word always starts the sequencer
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !stat.idle)
      else $error("sequencer stayed idle after an accepted word");

   // the engine never hands off into an occupied result register
   a_done_free: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> out_free)
      else $error("result hand-off while result register is full");

   // a hand-off always shows up as a pending result with the engine's value
   a_done_shown: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> rsp_ch.valid && rsp_ch.magnitude == $past(eng_mag))
      else $error("finished magnitude not presented");

endmodule

// File: rtl/ugm_csub.sv
// Shared compare-subtract unit: one restoring step of divide or square root.
// Depends on ugm_pkg.

module ugm_csub import ugm_pkg::*; (
   input  logic [CSUB_W-1:0] a,
   input  logic [CSUB_W-1:0] b,
   output logic              ge,
   output logic [CSUB_W-1:0] diff
);

   logic borrow;

   assign {borrow, diff} = {1'b0, a} - {1'b0, b};
   assign ge             = ~borrow;

endmodule

// File: rtl/ugm_engine.sv
// Sequencer and datapath: upwind select, serial divide, square, saturating
// accumulate, serial square root. Depends on ugm_pkg and ugm_csub.

module ugm_engine import ugm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  item_type          item,
   input  logic              out_free,
   output status_type        stat,
   output logic [MAG_W-1:0]  magnitude
);

   state_type            state_ff, state_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic                 last_ff, last_in;
   logic [SPACE_W-1:0]   spacing_ff, spacing_in;
   logic [DVD_W-1:0]     dq_ff, dq_in;        // dividend out at top, quotient in at bottom
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [GRAD_W-1:0]    g_ff, g_in;
   logic [SUM_W-1:0]     sq_ff, sq_in;

   logic [CSUB_W-1:0]    csub_a, csub_b, csub_diff;
   logic                 csub_ge;

   logic [FACE_W-1:0]    sel_upper, sel_lower, face_diff;
   logic [SPACE_W-1:0]   sel_spacing;
   logic signed [GRAD_W-1:0] sel_grad;
   logic [SUM_W:0]       acc_sum;

   ugm_csub u_csub (
      .a    (csub_a),
      .b    (csub_b),
      .ge   (csub_ge),
      .diff (csub_diff)
   );

   // upwind choice
   always_comb begin
      sel_upper   = item.flux_nonnegative ? item.upper_own     : item.upper_next;
      sel_lower   = item.flux_nonnegative ? item.lower_own     : item.lower_next;
      sel_spacing = item.flux_nonnegative ? item.spacing_own   : item.spacing_next;
      sel_grad    = item.flux_nonnegative ? item.gradient_own  : item.gradient_next;
      face_diff   = (sel_upper >= sel_lower) ? (sel_upper - sel_lower)
                                             : (sel_lower - sel_upper);
      acc_sum     = {1'b0, sum_ff} + {1'b0, sq_ff};
   end

   always_comb begin
      state_in   = state_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      last_in    = last_ff;
      spacing_in = spacing_ff;
      dq_in      = dq_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      g_in       = g_ff;
      sq_in      = sq_ff;
      csub_a     = '0;
      csub_b     = '0;
      stat       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            stat.idle = 1'b1;
            if (cmd.start) begin
               last_in = item.last_axis;
               unique case (cmd.mode) inside
                  MODE_DIFF, MODE_DIFF_ALT: begin
                     spacing_in = sel_spacing;
                     dq_in      = {face_diff, {FRACTION_BITS{1'b0}}};
                     rem_in     = '0;
                     cnt_in     = STEP_W'(DVD_W - 1);
                     if (face_diff == '0) begin
                        g_in     = '0;
                        state_in = ST_SQUARE;
                     end else if (sel_spacing == '0) begin
                        g_in     = GRAD_CAP;
                        state_in = ST_SQUARE;
                     end else begin
                        state_in = ST_DIVIDE;
                     end
                  end
                  MODE_SMOOTH: begin
                     g_in     = sel_grad[GRAD_W-1] ? $unsigned(GRAD_W'(-sel_grad))
                                                   : $unsigned(sel_grad);
                     state_in = ST_SQUARE;
                  end
                  default: begin
                     g_in     = '0;
                     state_in = ST_SQUARE;
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            csub_a = CSUB_W'({rem_ff[SPACE_W-1:0], dq_ff[DVD_W-1]});
            csub_b = CSUB_W'(spacing_ff);
            rem_in = REM_W'(csub_ge ? csub_diff[SPACE_W-1:0] : csub_a[SPACE_W-1:0]);
            dq_in  = {dq_ff[DVD_W-2:0], csub_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            g_in = ({{GRAD_W{1'b0}}, dq_ff} > {{DVD_W{1'b0}}, GRAD_CAP})
                   ? GRAD_CAP : GRAD_W'(dq_ff);
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            sq_in    = SUM_W'(g_ff) * SUM_W'(g_ff);
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            sum_in = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
            if (last_ff) begin
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = STEP_W'(ROOT_W - 1);
               state_in = ST_ROOT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ROOT: begin
            // two radicand bits per step; the sum drains to zero by the last step
            csub_a  = {rem_ff[REM_W-2:0], sum_ff[SUM_W-1 -: 2]};
            csub_b  = CSUB_W'({root_ff[ROOT_W-2:0], 2'b01});
            rem_in  = csub_ge ? csub_diff[REM_W-1:0] : csub_a[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], csub_ge};
            sum_in  = {sum_ff[SUM_W-3:0], 2'b00};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               stat.done = 1'b1;
               state_in  = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      last_ff    <= last_in;
      spacing_ff <= spacing_in;
      dq_ff      <= dq_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      g_ff       <= g_in;
      sq_ff      <= sq_in;
   end

   assign magnitude = MAG_W'(root_ff);

endmodule
